>>> hw/rtl/abkf_pkg.sv
// ============================================================================
// abkf_pkg
// Shared constants and types for the two-state angle and gyro-bias filter.
// ============================================================================
package abkf_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int AXES_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

    // Divider dividend width: |num| << 30 is at most 62 bits; the quotient fits in 62.
    localparam int DIV_QW    = 62;

    localparam logic [31:0] QA_RESET = 32'd16777;
    localparam logic [31:0] QB_RESET = 32'd50332;
    localparam logic [31:0] R_RESET  = 32'd503316;

    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QB = 2'd1;
    localparam logic [1:0] REG_R  = 2'd2;

    // Divider request and reply.
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;  // Signed Q8.24 numerator before the 2^30 scaling.
        logic        [33:0] den;  // Positive Q8.24 innovation variance.
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;  // Saturated Q2.30 gain.
    } t_div_rsp;

    // Saturate a 66-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (x > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (x < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

>>> hw/rtl/abkf_div.sv
// ============================================================================
// abkf_div
// Restoring divider: |num| * 2^30 / den, one quotient bit a cycle,
// truncated toward zero, signed and saturated to 32 bits.
// ============================================================================
module abkf_div
    import abkf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_QW-1:0] r_dvd;
    logic [34:0]   r_rem;
    logic [33:0]   r_den;
    logic          r_neg;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic signed [31:0] r_quo;

    logic [34:0] w_trial;
    logic [35:0] w_diff;
    logic [DIV_QW-1:0] w_qfin;
    logic [31:0] w_abs;
    logic signed [65:0] w_sq;

    always_comb begin
        w_trial = {r_rem[33:0], r_dvd[DIV_QW-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        w_qfin  = {r_dvd[DIV_QW-2:0], ~w_diff[35]};
        w_sq    = r_neg ? -$signed({4'b0000, w_qfin}) : $signed({4'b0000, w_qfin});
        w_abs   = i_req.num[31] ? (32'd0 - i_req.num) : i_req.num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_neg  <= i_req.num[31];
                r_dvd  <= {w_abs, 30'd0};
            end else if (r_busy) begin
                // Each step shifts one dividend bit in and the quotient bit
                // into the vacated low end of the same register.
                r_rem <= w_diff[35] ? w_trial : w_diff[34:0];
                r_dvd <= w_qfin;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= sat32(w_sq);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> hw/rtl/abkf_core.sv
// ============================================================================
// abkf_core
// Sequencer over one shared 33x34 multiplier, with per-axis state.
// ============================================================================
module abkf_core
    import abkf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [AXIS_W-1:0]   i_axis,
    input  logic signed [31:0]  i_meas,
    input  logic signed [31:0]  i_rate,
    input  logic [23:0]         i_dt,
    input  logic [31:0]         i_qa,
    input  logic [31:0]         i_qb,
    input  logic [31:0]         i_r,
    output t_div_req            o_div,
    input  t_div_rsp            i_div,
    output logic                o_done,
    output logic signed [31:0]  o_angle,
    output logic signed [31:0]  o_bias
);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_M_ANG, S_A_ANG, S_M_D, S_A_D, S_M_P00, S_A_P00,
        S_M_P11, S_A_P11, S_DIV0, S_W0, S_DIV1, S_W1,
        S_M_KA, S_A_KA, S_M_KB, S_A_KB, S_M_C0, S_A_C0, S_M_C1, S_A_C1,
        S_M_C2, S_A_C2, S_M_C3, S_A_C3, S_STORE
    } t_state;

    t_state r_state;

    logic signed [31:0] r_ang_mem [AXES];
    logic signed [31:0] r_bia_mem [AXES];
    logic signed [31:0] r_p_mem   [4*AXES];

    logic [AXES_IDX_W-1:0] r_ax;
    logic signed [31:0] r_ang, r_bia, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_n00, r_n01, r_n10, r_n11;
    logic signed [31:0] r_y, r_k0, r_k1, r_meas, r_rate;
    logic [23:0]        r_dt;
    logic signed [65:0] r_d;
    logic signed [65:0] r_prod;
    logic               r_spos;
    logic [33:0]        r_s;
    logic               r_done;
    logic signed [31:0] r_oang, r_obia;
    t_div_req           r_div;

    // Shared multiplier operands.
    logic signed [32:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [65:0] w_rnd16, w_rnd30;
    logic signed [65:0] w_inner_pre;
    logic signed [31:0] w_inner;
    logic signed [65:0] w_s;

    always_comb begin
        w_ma = 33'sd0;
        w_mb = 34'sd0;
        w_inner_pre = 66'(sat32(r_d)) - 66'(r_p01) - 66'(r_p10) + $signed({34'd0, i_qa});
        w_inner = sat32(w_inner_pre);
        case (r_state)
            S_M_ANG: begin
                w_ma = $signed({9'd0, r_dt});
                w_mb = 34'(r_rate) - 34'(r_bia);
            end
            S_M_D: begin
                w_ma = $signed({9'd0, r_dt});
                w_mb = 34'(r_p11);
            end
            S_M_P00: begin
                w_ma = $signed({9'd0, r_dt});
                w_mb = 34'(w_inner);
            end
            S_M_P11: begin
                w_ma = $signed({9'd0, r_dt});
                w_mb = $signed({2'b00, i_qb});
            end
            S_M_KA: begin w_ma = 33'(r_k0); w_mb = 34'(r_y);   end
            S_M_KB: begin w_ma = 33'(r_k1); w_mb = 34'(r_y);   end
            S_M_C0: begin w_ma = 33'(r_k0); w_mb = 34'(r_p00); end
            S_M_C1: begin w_ma = 33'(r_k0); w_mb = 34'(r_p01); end
            S_M_C2: begin w_ma = 33'(r_k1); w_mb = 34'(r_p00); end
            S_M_C3: begin w_ma = 33'(r_k1); w_mb = 34'(r_p01); end
            default: begin
                w_ma = 33'sd0;
                w_mb = 34'sd0;
            end
        endcase
        // Round half up, arithmetic shift is a floor.
        w_rnd16 = (r_prod + 66'sd32768) >>> 16;
        w_rnd30 = (r_prod + 66'sd536870912) >>> 30;
        w_s     = 66'(r_p00) + $signed({34'd0, i_r});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_div.start <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_ang_mem[i] <= '0;
                r_bia_mem[i] <= '0;
            end
            for (int i = 0; i < 4*AXES; i++) begin
                r_p_mem[i] <= '0;
            end
        end else begin
            r_done      <= 1'b0;
            r_div.start <= 1'b0;
            r_prod      <= 66'(w_ma * w_mb);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_meas <= i_meas;
                        r_rate <= i_rate;
                        r_dt   <= i_dt;
                        if (32'(i_axis) >= 32'(AXES)) begin
                            r_oang  <= '0;
                            r_obia  <= '0;
                            r_done  <= 1'b1;
                        end else begin
                            r_ax    <= AXES_IDX_W'(i_axis);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_ang   <= r_ang_mem[r_ax];
                    r_bia   <= r_bia_mem[r_ax];
                    r_p00   <= r_p_mem[4*r_ax];
                    r_p01   <= r_p_mem[4*r_ax+1];
                    r_p10   <= r_p_mem[4*r_ax+2];
                    r_p11   <= r_p_mem[4*r_ax+3];
                    r_state <= S_M_ANG;
                end
                S_M_ANG: r_state <= S_A_ANG;
                S_A_ANG: begin
                    r_ang   <= sat32(66'(r_ang) + w_rnd16);
                    r_state <= S_M_D;
                end
                S_M_D: r_state <= S_A_D;
                S_A_D: begin
                    r_d     <= w_rnd16;
                    r_state <= S_M_P00;
                end
                S_M_P00: r_state <= S_A_P00;
                S_A_P00: begin
                    r_p00   <= sat32(66'(r_p00) + w_rnd16);
                    r_p01   <= sat32(66'(r_p01) - r_d);
                    r_p10   <= sat32(66'(r_p10) - r_d);
                    r_state <= S_M_P11;
                end
                S_M_P11: r_state <= S_A_P11;
                S_A_P11: begin
                    r_p11   <= sat32(66'(r_p11) + w_rnd16);
                    r_y     <= sat32(66'(r_meas) - 66'(r_ang));
                    r_spos  <= (w_s > 66'sd0);
                    r_s     <= w_s[33:0];
                    r_state <= S_DIV0;
                end
                S_DIV0: begin
                    if (r_spos) begin
                        r_div.start <= 1'b1;
                        r_div.num   <= r_p00;
                        r_div.den   <= r_s;
                        r_state     <= S_W0;
                    end else begin
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_state <= S_M_KA;
                    end
                end
                S_W0: begin
                    if (i_div.done) begin
                        r_k0    <= i_div.quo;
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    r_div.start <= 1'b1;
                    r_div.num   <= r_p10;
                    r_div.den   <= r_s;
                    r_state     <= S_W1;
                end
                S_W1: begin
                    if (i_div.done) begin
                        r_k1    <= i_div.quo;
                        r_state <= S_M_KA;
                    end
                end
                S_M_KA: r_state <= S_A_KA;
                S_A_KA: begin
                    r_ang   <= sat32(66'(r_ang) + w_rnd30);
                    r_state <= S_M_KB;
                end
                S_M_KB: r_state <= S_A_KB;
                S_A_KB: begin
                    r_bia   <= sat32(66'(r_bia) + w_rnd30);
                    r_state <= S_M_C0;
                end
                S_M_C0: r_state <= S_A_C0;
                S_A_C0: begin
                    r_n00   <= sat32(66'(r_p00) - w_rnd30);
                    r_state <= S_M_C1;
                end
                S_M_C1: r_state <= S_A_C1;
                S_A_C1: begin
                    r_n01   <= sat32(66'(r_p01) - w_rnd30);
                    r_state <= S_M_C2;
                end
                S_M_C2: r_state <= S_A_C2;
                S_A_C2: begin
                    r_n10   <= sat32(66'(r_p10) - w_rnd30);
                    r_state <= S_M_C3;
                end
                S_M_C3: r_state <= S_A_C3;
                S_A_C3: begin
                    r_n11   <= sat32(66'(r_p11) - w_rnd30);
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    r_ang_mem[r_ax]   <= r_ang;
                    r_bia_mem[r_ax]   <= r_bia;
                    r_p_mem[4*r_ax]   <= r_n00;
                    r_p_mem[4*r_ax+1] <= r_n01;
                    r_p_mem[4*r_ax+2] <= r_n10;
                    r_p_mem[4*r_ax+3] <= r_n11;
                    r_oang  <= r_ang;
                    r_obia  <= r_bia;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_div   = r_div;
    assign o_done  = r_done;
    assign o_angle = r_oang;
    assign o_bias  = r_obia;

    // A divider reply only comes while the sequencer waits for one.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div.done |-> (r_state == S_W0 || r_state == S_W1))
        else $error("divider reply outside a wait state");

    // A finished update always returns to idle.
    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STORE |=> r_state == S_IDLE && r_done)
        else $error("store did not complete");

    // The divider is only started with a positive variance.
    a_div_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div.start |-> r_spos)
        else $error("divider started with nonpositive variance");

endmodule

>>> hw/rtl/angle_bias_kalman_filter.sv
// ============================================================================
// angle_bias_kalman_filter
// Two-state angle and gyro-bias filter for three axes, fixed point.
// ============================================================================
// Each word passes through the sequencer, whose steps share one 33x34
// multiplier; when the innovation variance is positive, two gain divisions
// run in turn in a bit-serial divider that yields 62 quotient bits; the
// result then goes to the output register. An out-of-range axis returns
// zeros. Input stall stays high while a word is in progress or a result
// waits in the output register.
module angle_bias_kalman_filter
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [AXIS_W-1:0]  i_axis,
    input  logic signed [31:0] i_measured_angle,
    input  logic signed [31:0] i_gyro_rate,
    input  logic [23:0]        i_time_step,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_filtered_angle,
    output logic signed [31:0] o_estimated_bias
);

    logic [31:0] r_qa, r_qb, r_r;
    logic        r_busy;
    logic        r_ovalid;
    logic signed [31:0] r_oang, r_obia;
    logic        w_accept;
    logic        w_done;
    logic signed [31:0] w_ang, w_bia;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    assign o_stall  = r_busy || r_ovalid;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa     <= QA_RESET;
            r_qb     <= QB_RESET;
            r_r      <= R_RESET;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_QA:  r_qa <= i_cfg_data;
                    REG_QB:  r_qb <= i_cfg_data;
                    REG_R:   r_r  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
                r_oang   <= w_ang;
                r_obia   <= w_bia;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    abkf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_axis  (i_axis),
        .i_meas  (i_measured_angle),
        .i_rate  (i_gyro_rate),
        .i_dt    (i_time_step),
        .i_qa    (r_qa),
        .i_qb    (r_qb),
        .i_r     (r_r),
        .o_div   (w_req),
        .i_div   (w_rsp),
        .o_done  (w_done),
        .o_angle (w_ang),
        .o_bias  (w_bia)
    );

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_valid          = r_ovalid;
    assign o_filtered_angle = r_oang;
    assign o_estimated_bias = r_obia;

endmodule

>>> tb/sv/angle_bias_kalman_filter_test.sv
`timescale 1ns / 100ps
// ============================================================================
// angle_bias_kalman_filter_test
// Drives measurement words into the angle and bias filter, predicts every
// result with a fixed-point model of its own and compares field by field,
// across several noise settings and idling phases.
// ============================================================================
module angle_bias_kalman_filter_test
    import abkf_pkg::*;
;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [AXIS_W-1:0]  i_axis;
    logic signed [31:0] i_measured_angle;
    logic signed [31:0] i_gyro_rate;
    logic [23:0]        i_time_step;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_filtered_angle;
    logic signed [31:0] o_estimated_bias;

    angle_bias_kalman_filter dut (.*);

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } t_estimate;

    typedef struct {
        logic [1:0]         axis;
        logic signed [31:0] meas;
        logic signed [31:0] rate;
        logic [23:0]        dt;
        logic               known;
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } t_row;

    // Filter state held by the predictor.
    logic signed [31:0] m_angle [AXES];
    logic signed [31:0] m_bias  [AXES];
    logic signed [31:0] m_cov   [AXES][4];
    logic [31:0]        m_qa, m_qb, m_r;

    t_estimate pending_estimates[$];
    int        error_count;
    int        watchdog;
    int        send_idle_pct, recv_stall_pct;

    localparam int WATCHDOG_LIMIT = 20000;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic longint rnd_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic t_estimate update_filter(logic [1:0] ax, logic signed [31:0] meas,
                                                logic signed [31:0] rate, logic [23:0] dt_in);
        t_estimate e;
        longint dt, ang, bia, p00, p01, p10, p11, d, inner, y, s, k0, k1;
        longint n00, n01, n10, n11;
        e.angle = 0;
        e.bias = 0;
        if (ax >= AXES) return e;
        dt = longint'(dt_in);
        ang = m_angle[ax];
        bia = m_bias[ax];
        p00 = m_cov[ax][0]; p01 = m_cov[ax][1]; p10 = m_cov[ax][2]; p11 = m_cov[ax][3];
        ang = clip32(ang + rnd_shift(dt * (longint'(rate) - bia), 16));
        d = rnd_shift(dt * p11, 16);
        inner = clip32(clip32(d) - p01 - p10 + longint'(m_qa));
        p00 = clip32(p00 + rnd_shift(dt * inner, 16));
        p01 = clip32(p01 - d);
        p10 = clip32(p10 - d);
        p11 = clip32(p11 + rnd_shift(longint'(m_qb) * dt, 16));
        y = clip32(longint'(meas) - ang);
        s = p00 + longint'(m_r);
        if (s > 0) begin
            k0 = clip32((p00 * (longint'(1) << 30)) / s);
            k1 = clip32((p10 * (longint'(1) << 30)) / s);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        ang = clip32(ang + rnd_shift(k0 * y, 30));
        bia = clip32(bia + rnd_shift(k1 * y, 30));
        n00 = clip32(p00 - rnd_shift(k0 * p00, 30));
        n01 = clip32(p01 - rnd_shift(k0 * p01, 30));
        n10 = clip32(p10 - rnd_shift(k1 * p00, 30));
        n11 = clip32(p11 - rnd_shift(k1 * p01, 30));
        m_cov[ax][0] = 32'(n00); m_cov[ax][1] = 32'(n01);
        m_cov[ax][2] = 32'(n10); m_cov[ax][3] = 32'(n11);
        m_angle[ax] = 32'(ang);
        m_bias[ax] = 32'(bia);
        e.angle = 32'(ang);
        e.bias = 32'(bia);
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Result checking and receiver stalls.
    always @(posedge i_clk) begin
        t_estimate e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_estimates.size() == 0) begin
                    report_mismatch("unexpected word", o_filtered_angle, 0);
                end else begin
                    e = pending_estimates.pop_front();
                    if (o_filtered_angle !== e.angle)
                        report_mismatch("filtered_angle", o_filtered_angle, e.angle);
                    if (o_estimated_bias !== e.bias)
                        report_mismatch("estimated_bias", o_estimated_bias, e.bias);
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted word and no taken result.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
        end
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("angle_bias_kalman_filter_test NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_QA:  m_qa = val;
            REG_QB:  m_qb = val;
            REG_R:   m_r  = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Presents one word and waits for it to be taken; the prediction is queued
    // at the accepting edge.
    task automatic send_word(t_row r);
        t_estimate e;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid          <= 1'b1;
        i_axis           <= r.axis;
        i_measured_angle <= r.meas;
        i_gyro_rate      <= r.rate;
        i_time_step      <= r.dt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        e = update_filter(r.axis, r.meas, r.rate, r.dt);
        if (r.known) begin
            e.angle = r.angle;
            e.bias  = r.bias;
        end
        pending_estimates.push_back(e);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            2:       return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
        endcase
    endfunction

    function automatic t_row rand_row();
        t_row r;
        r.known = 1'b0;
        r.angle = 0;
        r.bias  = 0;
        r.axis  = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(AXES - 1));
        r.meas  = rand_angle();
        r.rate  = rand_angle();
        case ($urandom_range(3))
            0:       r.dt = 24'($urandom);
            1:       r.dt = 24'($urandom_range(0, 24'h0001FF));
            default: r.dt = 24'($urandom_range(24'h000020, 24'h000400));
        endcase
        return r;
    endfunction

    t_row directed[] = '{
        // Fresh axis with zero time step and zero measurement: all zeros.
        '{2'd0, 32'sd0, 32'sd0, 24'd0, 1'b1, 32'sd0, 32'sd0},
        // An out-of-range axis returns zeros and changes nothing.
        '{2'd3, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF, 1'b1, 32'sd0, 32'sd0},
        '{2'd3, 32'sh80000000, 32'sh80000000, 24'd0, 1'b1, 32'sd0, 32'sd0},
        '{2'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF, 1'b0, 32'sd0, 32'sd0},
        '{2'd0, 32'sh80000000, 32'sh80000000, 24'hFFFFFF, 1'b0, 32'sd0, 32'sd0},
        '{2'd1, 32'sh80000000, 32'sh7FFFFFFF, 24'h010000, 1'b0, 32'sd0, 32'sd0},
        '{2'd1, 32'sh00010000, 32'sh00000000, 24'h000100, 1'b0, 32'sd0, 32'sd0},
        '{2'd2, 32'sh00050000, 32'shFFFF0000, 24'h000080, 1'b0, 32'sd0, 32'sd0},
        '{2'd2, 32'shFFFB0000, 32'sh00020000, 24'h000080, 1'b0, 32'sd0, 32'sd0},
        '{2'd2, 32'sh00000000, 32'sh00000000, 24'h000000, 1'b0, 32'sd0, 32'sd0},
        '{2'd0, 32'sh12345678, 32'shEDCBA987, 24'h000001, 1'b0, 32'sd0, 32'sd0}
    };

    initial begin
        logic [31:0] qa_set[5] = '{32'd0, 32'hFFFFFFFF, 32'd16777, 32'd1, 32'd1000000};
        logic [31:0] qb_set[5] = '{32'd0, 32'hFFFFFFFF, 32'd50332, 32'd7, 32'd200000};
        logic [31:0] r_set[5]  = '{32'd0, 32'hFFFFFFFF, 32'd503316, 32'd1, 32'h01000000};
        int idle_s[4] = '{0, 52, 0, 12};
        int idle_r[4] = '{0, 0, 52, 12};
        int phase;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_axis = '0;
        i_measured_angle = '0;
        i_gyro_rate = '0;
        i_time_step = '0;
        error_count = 0;
        watchdog = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        m_qa = QA_RESET;
        m_qb = QB_RESET;
        m_r  = R_RESET;
        for (int a = 0; a < AXES; a++) begin
            m_angle[a] = 0;
            m_bias[a]  = 0;
            for (int k = 0; k < 4; k++) m_cov[a][k] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_word(directed[i]);
        wait_drained();
        // An index above the last register must be ignored.
        write_reg(2'd3, 32'hDEADBEEF);

        for (int i = 0; i < 800; i++) begin
            if (i % 40 == 0) begin
                wait_drained();
                phase = (i / 40) % 4;
                send_idle_pct  = idle_s[phase];
                recv_stall_pct = idle_r[phase];
                write_reg(REG_QA, ($urandom_range(2) == 0) ? $urandom
                                                           : qa_set[$urandom_range(4)]);
                write_reg(REG_QB, ($urandom_range(2) == 0) ? $urandom
                                                           : qb_set[$urandom_range(4)]);
                write_reg(REG_R, ($urandom_range(2) == 0) ? $urandom
                                                          : r_set[$urandom_range(4)]);
            end
            send_word(rand_row());
        end

        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("angle_bias_kalman_filter_test OK");
        end else begin
            $display("angle_bias_kalman_filter_test NOT OK");
        end
        $finish;
    end

endmodule
